>>> rtl/cppf_pkg.sv
// ----------------------------------------------------------------------------
// cppf_pkg
// Shared constants, control word and status types, and the microprogram ROM
// of the closest prime pair finder.
// ----------------------------------------------------------------------------
package cppf_pkg;

    // Size of the prime bitmap; upper bounds must stay below it
    localparam int MAX_VALUE = 65536;

    // Field widths of the query and result items
    localparam int IN_W  = 16;
    localparam int OUT_W = 16;

    // Bitmap address, sieve counters (hold values below twice the map size) and scan counter
    localparam int ADDR_W = $clog2(MAX_VALUE);
    localparam int CNT_W  = ADDR_W + 1;
    localparam int NW     = (CNT_W > IN_W + 1) ? CNT_W : IN_W + 1;

    // Datapath operations, one per control word
    typedef enum logic [3:0] {
        OP_NOP,
        OP_CLR_J,
        OP_FILL,
        OP_INIT_I,
        OP_READ_I,
        OP_LOAD_J,
        OP_MARK,
        OP_NEXT_I,
        OP_ACCEPT,
        OP_READ_N,
        OP_EVAL,
        OP_EMIT
    } dp_op_t;

    // Jump conditions; a control word jumps to its target when its condition holds
    typedef enum logic [3:0] {
        C_NEXT,
        C_ALWAYS,
        C_NOT_J_LAST,
        C_SQ_GE,
        C_NOT_RD,
        C_J_LT,
        C_NOT_QUERY,
        C_OOR,
        C_N_GT_HI,
        C_OUT_FREE
    } cond_t;

    typedef logic [3:0] upc_t;

    // Step addresses of the microprogram
    localparam upc_t S_FILL_INIT = 4'd0;
    localparam upc_t S_FILL      = 4'd1;
    localparam upc_t S_SV_INIT   = 4'd2;
    localparam upc_t S_SV_TEST   = 4'd3;
    localparam upc_t S_SV_CHK    = 4'd4;
    localparam upc_t S_SV_MARK   = 4'd5;
    localparam upc_t S_SV_NEXT   = 4'd6;
    localparam upc_t S_IDLE      = 4'd7;
    localparam upc_t S_RANGE     = 4'd8;
    localparam upc_t S_SCAN_RD   = 4'd9;
    localparam upc_t S_SCAN_EV   = 4'd10;
    localparam upc_t S_EMIT      = 4'd11;
    localparam upc_t S_EMIT_WAIT = 4'd12;

    typedef struct packed {
        dp_op_t op;
        cond_t  cond;
        upc_t   target;
    } uword_t;

    // Status flags from the datapath to the sequencer
    typedef struct packed {
        logic j_last;
        logic j_lt;
        logic sq_ge;
        logic rd_bit;
        logic query;
        logic oor;
        logic n_gt_hi;
        logic out_free;
    } stat_t;

    // Microprogram ROM
    function automatic uword_t ucode(upc_t addr);
        uword_t w;
        unique case (addr)
            S_FILL_INIT: w = '{OP_CLR_J,  C_NEXT,       S_FILL_INIT};
            S_FILL:      w = '{OP_FILL,   C_NOT_J_LAST, S_FILL};
            S_SV_INIT:   w = '{OP_INIT_I, C_NEXT,       S_FILL_INIT};
            S_SV_TEST:   w = '{OP_READ_I, C_SQ_GE,      S_IDLE};
            S_SV_CHK:    w = '{OP_LOAD_J, C_NOT_RD,     S_SV_NEXT};
            S_SV_MARK:   w = '{OP_MARK,   C_J_LT,       S_SV_MARK};
            S_SV_NEXT:   w = '{OP_NEXT_I, C_ALWAYS,     S_SV_TEST};
            S_IDLE:      w = '{OP_ACCEPT, C_NOT_QUERY,  S_IDLE};
            S_RANGE:     w = '{OP_NOP,    C_OOR,        S_EMIT};
            S_SCAN_RD:   w = '{OP_READ_N, C_N_GT_HI,    S_EMIT};
            S_SCAN_EV:   w = '{OP_EVAL,   C_ALWAYS,     S_SCAN_RD};
            S_EMIT:      w = '{OP_EMIT,   C_OUT_FREE,   S_IDLE};
            S_EMIT_WAIT: w = '{OP_NOP,    C_ALWAYS,     S_EMIT};
            default:     w = '{OP_NOP,    C_ALWAYS,     S_FILL_INIT};
        endcase
        return w;
    endfunction

endpackage

>>> rtl/cppf_useq.sv
// ----------------------------------------------------------------------------
// cppf_useq
// Microsequencer: step counter, control word fetch from the ROM and
// conditional jumps on datapath status.
// ----------------------------------------------------------------------------
module cppf_useq
    import cppf_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  stat_t  stat,
    output dp_op_t op
);

    upc_t   upc_reg;
    upc_t   upc_next;
    uword_t uw;
    logic   take;

    // Fetch the control word of the current step
    assign uw = ucode(upc_reg);
    assign op = uw.op;

    // Evaluate the jump condition
    always_comb
    begin
        unique case (uw.cond)
            C_NEXT:       take = 1'b0;
            C_ALWAYS:     take = 1'b1;
            C_NOT_J_LAST: take = !stat.j_last;
            C_SQ_GE:      take = stat.sq_ge;
            C_NOT_RD:     take = !stat.rd_bit;
            C_J_LT:       take = stat.j_lt;
            C_NOT_QUERY:  take = !stat.query;
            C_OOR:        take = stat.oor;
            C_N_GT_HI:    take = stat.n_gt_hi;
            C_OUT_FREE:   take = stat.out_free;
            default:      take = 1'b0;
        endcase
    end

    // Jump or advance
    assign upc_next = take ? uw.target : upc_t'(upc_reg + 4'd1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            upc_reg <= S_FILL_INIT;
        else
            upc_reg <= upc_next;
    end

endmodule

>>> rtl/cppf_dp.sv
// ----------------------------------------------------------------------------
// cppf_dp
// Datapath: prime bitmap memory, sieve counters, scan registers for the
// closest pair and the result register.
// ----------------------------------------------------------------------------
module cppf_dp
    import cppf_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  dp_op_t           op,
    output stat_t            stat,
    input  logic             query_valid,
    input  logic [IN_W-1:0]  range_low,
    input  logic [IN_W-1:0]  range_high,
    input  logic             result_stall,
    output logic             result_valid,
    output logic             found,
    output logic             out_of_range,
    output logic [OUT_W-1:0] first_prime,
    output logic [OUT_W-1:0] second_prime
);

    // Prime bitmap
    logic mem [MAX_VALUE];
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic              mem_wdata;
    logic [ADDR_W-1:0] mem_raddr;
    logic              rd_bit_reg;

    // Sieve counters
    logic [CNT_W-1:0] i_reg, i_next;
    logic [CNT_W-1:0] sq_reg, sq_next;
    logic [CNT_W-1:0] j_reg, j_next;

    // Scan registers
    logic [NW-1:0]     n_reg, n_next;
    logic [IN_W-1:0]   hi_reg, hi_next;
    logic [ADDR_W-1:0] prev_reg, prev_next;
    logic [ADDR_W-1:0] best_a_reg, best_a_next;
    logic [ADDR_W-1:0] best_b_reg, best_b_next;
    logic [ADDR_W-1:0] best_d_reg, best_d_next;
    logic              have_prev_reg, have_prev_next;
    logic              have_pair_reg, have_pair_next;
    logic [ADDR_W-1:0] diff;

    // Result register
    logic             rv_reg, rv_next;
    logic             found_reg, found_next;
    logic             oor_reg, oor_next;
    logic [OUT_W-1:0] first_reg, first_next;
    logic [OUT_W-1:0] second_reg, second_next;

    // Status toward the sequencer
    assign stat.j_last   = (j_reg == CNT_W'(MAX_VALUE - 1));
    assign stat.j_lt     = (j_reg < CNT_W'(MAX_VALUE));
    assign stat.sq_ge    = (sq_reg >= CNT_W'(MAX_VALUE));
    assign stat.rd_bit   = rd_bit_reg;
    assign stat.query    = query_valid;
    assign stat.oor      = (32'(hi_reg) > 32'(MAX_VALUE - 1));
    assign stat.n_gt_hi  = (n_reg > NW'(hi_reg));
    assign stat.out_free = !rv_reg || !result_stall;

    // Memory port control: fill clears 0 and 1 and sets the rest, marking clears
    assign mem_we    = (op == OP_FILL) || ((op == OP_MARK) && stat.j_lt);
    assign mem_waddr = j_reg[ADDR_W-1:0];
    assign mem_wdata = (op == OP_FILL) && (j_reg >= CNT_W'(2));
    assign mem_raddr = (op == OP_READ_I) ? i_reg[ADDR_W-1:0] : n_reg[ADDR_W-1:0];

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        rd_bit_reg <= mem[mem_raddr];
    end

    assign diff = n_reg[ADDR_W-1:0] - prev_reg;

    // Next values of the counters and scan registers
    always_comb
    begin
        i_next         = i_reg;
        sq_next        = sq_reg;
        j_next         = j_reg;
        n_next         = n_reg;
        hi_next        = hi_reg;
        prev_next      = prev_reg;
        best_a_next    = best_a_reg;
        best_b_next    = best_b_reg;
        best_d_next    = best_d_reg;
        have_prev_next = have_prev_reg;
        have_pair_next = have_pair_reg;
        unique case (op)
            OP_CLR_J:
                j_next = '0;
            OP_FILL:
                j_next = CNT_W'(j_reg + 1'b1);
            OP_INIT_I:
            begin
                i_next  = CNT_W'(2);
                sq_next = CNT_W'(4);
            end
            OP_LOAD_J:
                j_next = sq_reg;
            OP_MARK:
                if (stat.j_lt)
                    j_next = CNT_W'(j_reg + i_reg);
            OP_NEXT_I:
            begin
                // (i+1)^2 = i^2 + 2i + 1
                i_next  = CNT_W'(i_reg + 1'b1);
                sq_next = CNT_W'(sq_reg + {i_reg, 1'b1});
            end
            OP_ACCEPT:
                if (query_valid)
                begin
                    n_next         = NW'(range_low);
                    hi_next        = range_high;
                    have_prev_next = 1'b0;
                    have_pair_next = 1'b0;
                end
            OP_EVAL:
            begin
                if (rd_bit_reg)
                begin
                    // Strict compare keeps the earliest of tied pairs
                    if (have_prev_reg && (!have_pair_reg || (diff < best_d_reg)))
                    begin
                        best_d_next    = diff;
                        best_a_next    = prev_reg;
                        best_b_next    = n_reg[ADDR_W-1:0];
                        have_pair_next = 1'b1;
                    end
                    prev_next      = n_reg[ADDR_W-1:0];
                    have_prev_next = 1'b1;
                end
                n_next = NW'(n_reg + 1'b1);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        i_reg      <= i_next;
        sq_reg     <= sq_next;
        j_reg      <= j_next;
        n_reg      <= n_next;
        hi_reg     <= hi_next;
        prev_reg   <= prev_next;
        best_a_reg <= best_a_next;
        best_b_reg <= best_b_next;
        best_d_reg <= best_d_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_prev_reg <= 1'b0;
            have_pair_reg <= 1'b0;
        end
        else
        begin
            have_prev_reg <= have_prev_next;
            have_pair_reg <= have_pair_next;
        end
    end

    // Load the result register when free, drop valid once the item is taken
    always_comb
    begin
        rv_next     = rv_reg;
        found_next  = found_reg;
        oor_next    = oor_reg;
        first_next  = first_reg;
        second_next = second_reg;
        if (rv_reg && !result_stall)
            rv_next = 1'b0;
        if ((op == OP_EMIT) && stat.out_free)
        begin
            rv_next     = 1'b1;
            found_next  = have_pair_reg;
            oor_next    = stat.oor;
            first_next  = have_pair_reg ? OUT_W'(best_a_reg) : '0;
            second_next = have_pair_reg ? OUT_W'(best_b_reg) : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rv_reg <= 1'b0;
        else
            rv_reg <= rv_next;
    end

    always_ff @(posedge clk)
    begin
        found_reg  <= found_next;
        oor_reg    <= oor_next;
        first_reg  <= first_next;
        second_reg <= second_next;
    end

    assign result_valid = rv_reg;
    assign found        = found_reg;
    assign out_of_range = oor_reg;
    assign first_prime  = first_reg;
    assign second_prime = second_reg;

endmodule

>>> rtl/closest_prime_pair_finder.sv
// ----------------------------------------------------------------------------
// closest_prime_pair_finder
// Range query engine returning the closest pair of consecutive primes.
// ----------------------------------------------------------------------------
// After reset the block fills its prime bitmap and runs a sieve of
// Eratosthenes over it; query_stall stays high until that is done. A query
// walks the entries in [range_low, range_high] (none for an empty range) at
// a pace set by the single bitmap memory port: each entry is read in one
// step and evaluated in the next. The last step waits while the previous
// result is still stalled on the output. One query is worked on at a time;
// a finished result waits in an output register while the next query is
// accepted. A query with range_high above MAX_VALUE-1 returns out_of_range
// with found low.
module closest_prime_pair_finder
    import cppf_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             query_valid,
    output logic             query_stall,
    input  logic [IN_W-1:0]  range_low,
    input  logic [IN_W-1:0]  range_high,
    output logic             result_valid,
    input  logic             result_stall,
    output logic             found,
    output logic             out_of_range,
    output logic [OUT_W-1:0] first_prime,
    output logic [OUT_W-1:0] second_prime
);

    dp_op_t op;
    stat_t  stat;

    // Accept a query only in the idle step of the program
    assign query_stall = (op != OP_ACCEPT);

    cppf_useq u_useq (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .op    (op)
    );

    cppf_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .op           (op),
        .stat         (stat),
        .query_valid  (query_valid),
        .range_low    (range_low),
        .range_high   (range_high),
        .result_stall (result_stall),
        .result_valid (result_valid),
        .found        (found),
        .out_of_range (out_of_range),
        .first_prime  (first_prime),
        .second_prime (second_prime)
    );

endmodule

>>> rtl/cppf_checker.sv
// ----------------------------------------------------------------------------
// cppf_checker
// Port-level checks on the result channel of the closest prime pair finder.
// ----------------------------------------------------------------------------
module cppf_checker
    import cppf_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             result_valid,
    input logic             result_stall,
    input logic             found,
    input logic             out_of_range,
    input logic [OUT_W-1:0] first_prime,
    input logic [OUT_W-1:0] second_prime
);

    // Hold a stalled result item
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=>
            result_valid && $stable(found) && $stable(out_of_range)
            && $stable(first_prime) && $stable(second_prime))
        else $error("stalled result item changed");

    // An unanswered query never reports a pair
    a_oor: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && out_of_range |-> !found)
        else $error("out_of_range item reports a pair");

    // No pair means both primes read zero
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !found |-> (first_prime == '0) && (second_prime == '0))
        else $error("primes not zero without a pair");

    // A pair is ordered and starts at two or above
    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && found |-> (first_prime < second_prime) && (first_prime >= OUT_W'(2)))
        else $error("found pair out of order");

endmodule

bind closest_prime_pair_finder cppf_checker u_cppf_checker (.*);

>>> tb/closest_prime_pair_checker.sv
// ----------------------------------------------------------------------------
// closest_prime_pair_checker
// Watches the query and result channels of the closest prime pair finder,
// predicts the answer of every accepted query from its own prime bitmap and
// compares each accepted result, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module closest_prime_pair_checker
    import cppf_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             query_valid,
    input  logic             query_stall,
    input  logic [IN_W-1:0]  range_low,
    input  logic [IN_W-1:0]  range_high,
    input  logic             result_valid,
    input  logic             result_stall,
    input  logic             found,
    input  logic             out_of_range,
    input  logic [OUT_W-1:0] first_prime,
    input  logic [OUT_W-1:0] second_prime,
    output int               errors,
    output int               outstanding
);

    // One answer, in the order of the result ports
    typedef struct packed {
        logic             found;
        logic             oor;
        logic [OUT_W-1:0] lo_prime;
        logic [OUT_W-1:0] hi_prime;
    } prime_pair_t;

    bit          is_prime [MAX_VALUE];
    prime_pair_t pair_q [$];
    int          fails;

    // Build the bitmap once with a sieve of Eratosthenes
    initial
    begin
        for (int n = 0; n < MAX_VALUE; n++)
            is_prime[n] = (n >= 2);
        for (int p = 2; p * p < MAX_VALUE; p++)
        begin
            if (is_prime[p])
            begin
                for (int m = p * p; m < MAX_VALUE; m += p)
                    is_prime[m] = 1'b0;
            end
        end
    end

    // Scan the range upward; a later pair replaces the best only if strictly closer
    function automatic prime_pair_t closest_pair(logic [IN_W-1:0] lo, logic [IN_W-1:0] hi);
        prime_pair_t res;
        int          prev;
        int          gap;
        int          best;
        res  = '0;
        prev = -1;
        best = 0;
        if (int'(hi) > MAX_VALUE - 1)
        begin
            res.oor = 1'b1;
            return res;
        end
        for (int n = int'(lo); n <= int'(hi); n++)
        begin
            if (is_prime[n])
            begin
                if (prev >= 0)
                begin
                    gap = n - prev;
                    if (!res.found || gap < best)
                    begin
                        best         = gap;
                        res.found    = 1'b1;
                        res.lo_prime = OUT_W'(prev);
                        res.hi_prime = OUT_W'(n);
                    end
                end
                prev = n;
            end
        end
        return res;
    endfunction

    // Check results first, then record the query of the same edge
    always @(posedge clk)
    begin
        prime_pair_t got;
        prime_pair_t want;
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                got = '{found, out_of_range, first_prime, second_prime};
                if (pair_q.size() == 0)
                begin
                    fails++;
                    if (fails <= 10)
                        $display("[%0t] result with no query pending: %s=%0b oor=%0b pair=(%0d,%0d)",
                                 $time, "found", got.found, got.oor,
                                 got.lo_prime, got.hi_prime);
                end
                else
                begin
                    want = pair_q.pop_front();
                    if (got !== want)
                    begin
                        fails++;
                        if (fails <= 10)
                        begin
                            $display("[%0t] mismatch: expected found=%0b oor=%0b pair=(%0d,%0d),",
                                     $time, want.found, want.oor,
                                     want.lo_prime, want.hi_prime);
                            $display("    got found=%0b oor=%0b pair=(%0d,%0d)",
                                     got.found, got.oor, got.lo_prime, got.hi_prime);
                        end
                    end
                end
            end
            if (query_valid && !query_stall)
                pair_q.insert(pair_q.size(), closest_pair(range_low, range_high));
            outstanding <= pair_q.size();
            errors      <= fails;
        end
    end

endmodule

>>> tb/closest_prime_pair_finder_test.sv
// ----------------------------------------------------------------------------
// closest_prime_pair_finder_test
// Drives range queries into the closest prime pair finder and gives the verdict.
// ----------------------------------------------------------------------------
// Reset is followed by the block's own sieve pass. A directed set covers the
// bounds, empty and one-prime ranges, ties and the full range; random queries
// follow, mostly short ranges spread over the whole field, with random gaps on
// both channels apart from one long calm stretch. The checker predicts and
// compares; this module stops on a stuck channel or at the end.
// ----------------------------------------------------------------------------
module closest_prime_pair_finder_test
    import cppf_pkg::*;
();

    // Longest run of edges with no item moving; the sieve and a full-range
    // query are the slowest quiet spells
    localparam int IDLE_LIMIT = 1_000_000;
    localparam int RAND_QUERIES = 100;

    logic             clk;
    logic             rst_n;
    logic             query_valid;
    logic             query_stall;
    logic [IN_W-1:0]  range_low;
    logic [IN_W-1:0]  range_high;
    logic             result_valid;
    logic             result_stall;
    logic             found;
    logic             out_of_range;
    logic [OUT_W-1:0] first_prime;
    logic [OUT_W-1:0] second_prime;
    logic             calm;
    int               errors;
    int               outstanding;
    int               idle_cycles;

    closest_prime_pair_finder i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .query_valid  (query_valid),
        .query_stall  (query_stall),
        .range_low    (range_low),
        .range_high   (range_high),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .found        (found),
        .out_of_range (out_of_range),
        .first_prime  (first_prime),
        .second_prime (second_prime)
    );

    closest_prime_pair_checker i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .query_valid  (query_valid),
        .query_stall  (query_stall),
        .range_low    (range_low),
        .range_high   (range_high),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .found        (found),
        .out_of_range (out_of_range),
        .first_prime  (first_prime),
        .second_prime (second_prime),
        .errors       (errors),
        .outstanding  (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Stall the result side at random except in the calm stretch
    always @(posedge clk)
        result_stall <= !calm && ($urandom_range(99) < 26);

    // Offer one query, with random idle cycles first, and hold it until taken
    task automatic send_query(input logic [IN_W-1:0] lo, input logic [IN_W-1:0] hi);
        while (!calm && $urandom_range(99) < 26)
        begin
            query_valid <= 1'b0;
            @(posedge clk);
        end
        query_valid <= 1'b1;
        range_low   <= lo;
        range_high  <= hi;
        do @(posedge clk); while (query_stall !== 1'b0);
    endtask

    // Drop valid and hold off until every predicted result has come back
    task automatic drain_results;
        query_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    // Pick a query: mostly short ranges anywhere, some longer, empty or edge ones
    task automatic random_query;
        int kind;
        int lo;
        int hi;
        kind = $urandom_range(99);
        lo   = $urandom_range(16'hFFFF);
        if (kind < 75)
            hi = lo + $urandom_range(300);
        else if (kind < 85)
            hi = lo + $urandom_range(4000);
        else if (kind < 92)
        begin
            if (lo == 0)
                lo = 1;
            hi = $urandom_range(lo - 1);
        end
        else if (kind < 97)
        begin
            lo = $urandom_range(8);
            hi = lo + $urandom_range(12);
        end
        else
        begin
            lo = 16'hFFFF - $urandom_range(400);
            hi = 16'hFFFF;
        end
        if (hi > 16'hFFFF)
            hi = 16'hFFFF;
        send_query(IN_W'(lo), IN_W'(hi));
    endtask

    // End the run if no item moves for too long
    initial
    begin
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((query_valid && !query_stall) || (result_valid && !result_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n       <= 1'b0;
        query_valid <= 1'b0;
        range_low   <= '0;
        range_high  <= '0;
        calm        <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: bounds, no primes, one prime, ties, gaps and the full map
        send_query(16'd0, 16'd0);
        send_query(16'd0, 16'd1);
        send_query(16'd0, 16'd2);
        send_query(16'd2, 16'd3);
        send_query(16'd1, 16'd3);
        send_query(16'd7, 16'd7);
        send_query(16'd0, 16'd10);
        send_query(16'd3, 16'd20);
        send_query(16'd24, 16'd28);
        send_query(16'd113, 16'd127);
        send_query(16'd89, 16'd97);
        send_query(16'd10, 16'd5);
        send_query(16'hFFFF, 16'h0000);
        send_query(16'hFFFF, 16'hFFFF);
        send_query(16'd65521, 16'hFFFF);
        send_query(16'd65000, 16'hFFFF);
        send_query(16'hAAAA, 16'hAAAA + 16'd300);
        send_query(16'h5555, 16'h5555 + 16'd300);
        send_query(16'd32749, 16'd32789);
        send_query(16'd0, 16'hFFFF);
        drain_results();

        // Random part, with a calm stretch in the middle
        for (int k = 0; k < RAND_QUERIES; k++)
        begin
            calm <= (k >= 40 && k < 70);
            random_query();
        end
        calm <= 1'b0;

        drain_results();
        repeat (20) @(posedge clk);
        if (errors == 0 && outstanding == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
